FILE: hw/rtl/csv_tok_pkg.sv
// shared types, constants and byte codes of the csv byte tokenizer
package csv_tok_pkg;

    localparam int POSITION_BITS = 32;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_QUOTE = 8'd34;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [2:0] CFG_DELIMITER = 3'd0;
    localparam logic [2:0] CFG_QUOTE     = 3'd1;
    localparam logic [2:0] CFG_ESCAPE    = 3'd2;
    localparam logic [2:0] CFG_COMMENT   = 3'd3;
    localparam logic [2:0] CFG_OPTIONS   = 3'd4;
    localparam logic [2:0] CFG_MAX_ROW   = 3'd5;
    localparam logic [2:0] CFG_FIRST     = 3'd6;
    localparam logic [2:0] CFG_LAST      = 3'd7;

    typedef enum logic [1:0] {
        EV_FIELD        = 2'd0,
        EV_ROW_END      = 2'd1,
        EV_ROW_TOO_LONG = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        Q_UNQUOTED = 2'd0,
        Q_QUOTED   = 2'd1,
        Q_ESCAPE   = 2'd2
    } quote_state_t;

    typedef struct packed {
        logic [7:0]  delimiter_byte;
        logic [7:0]  quote_byte;
        logic [7:0]  escape_byte;
        logic [7:0]  comment_byte;
        logic [1:0]  option_bits;
        logic [31:0] max_row_bytes;
        logic [31:0] first_line;
        logic [31:0] last_line;
    } cfg_t;

    typedef struct packed {
        event_kind_t kind;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] line;
        logic        last;
    } event_t;

    typedef struct packed {
        logic [1:0]       count;
        event_t [1:0]     ev;
    } push_t;

endpackage

FILE: hw/rtl/csv_byte_tokenizer.sv
// top level of the csv byte tokenizer: config registers, parser and result queue
//
//  channel | direction | beat contents
//  --------+-----------+-----------------------------------------------------
//  in      | sink      | data_byte, end_of_input
//  out     | source    | event_kind, field_offset, field_length, line_number,
//          |           | last_of_run
//  cfg     | write     | cfg_index selects register, cfg_data written on cfg_we
//
// one input byte per cycle while the input is not stalled; a taken byte waits in the
// input register until the queue has room, and its events are then written to the queue
// a byte can give two events, which are given out one at a time; the four-entry queue sets
// the input stall when fewer than two entries are free
// reset clears parse state, line count to one, and config to its defaults

module csv_byte_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [31:0] field_offset,
    output logic [31:0] field_length,
    output logic [31:0] line_number,
    output logic        last_of_run,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    csv_tok_pkg::cfg_t   cfg_reg;
    csv_tok_pkg::push_t  push;
    csv_tok_pkg::event_t head;
    logic                room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter_byte <= csv_tok_pkg::CH_COMMA;
            cfg_reg.quote_byte     <= csv_tok_pkg::CH_QUOTE;
            cfg_reg.escape_byte    <= 8'd0;
            cfg_reg.comment_byte   <= 8'd0;
            cfg_reg.option_bits    <= 2'd0;
            cfg_reg.max_row_bytes  <= 32'd0;
            cfg_reg.first_line     <= 32'd1;
            cfg_reg.last_line      <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csv_tok_pkg::CFG_DELIMITER: cfg_reg.delimiter_byte <= cfg_data[7:0];
                csv_tok_pkg::CFG_QUOTE:     cfg_reg.quote_byte     <= cfg_data[7:0];
                csv_tok_pkg::CFG_ESCAPE:    cfg_reg.escape_byte    <= cfg_data[7:0];
                csv_tok_pkg::CFG_COMMENT:   cfg_reg.comment_byte   <= cfg_data[7:0];
                csv_tok_pkg::CFG_OPTIONS:   cfg_reg.option_bits    <= cfg_data[1:0];
                csv_tok_pkg::CFG_MAX_ROW:   cfg_reg.max_row_bytes  <= cfg_data;
                csv_tok_pkg::CFG_FIRST:     cfg_reg.first_line     <= cfg_data;
                csv_tok_pkg::CFG_LAST:      cfg_reg.last_line      <= cfg_data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    csv_tok_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .cfg          (cfg_reg),
        .room         (room),
        .push         (push)
    );

    csv_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign event_kind   = head.kind;
    assign field_offset = head.offset;
    assign field_length = head.length;
    assign line_number  = head.line;
    assign last_of_run  = head.last;

endmodule

FILE: hw/rtl/csv_tok_parser.sv
// input register, parse state and per-byte event generation
module csv_tok_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                end_of_input,
    input  csv_tok_pkg::cfg_t   cfg,
    input  logic                room,
    output csv_tok_pkg::push_t  push
);

    localparam int PW = csv_tok_pkg::POSITION_BITS;

    logic                      ib_valid_reg, ib_valid_next;
    logic [7:0]                ib_byte_reg;
    logic                      ib_eoi_reg;
    logic                      accept, fire;

    csv_tok_pkg::quote_state_t qs_reg, qs_next;
    logic                      comment_reg, comment_next;
    logic                      disc_reg, disc_next;
    logic [PW-1:0]             pos_reg, pos_next;
    logic [PW-1:0]             fb_reg, fb_next;
    logic [PW-1:0]             fn_reg, fn_next;
    logic [PW-1:0]             ne_reg, ne_next;
    logic                      seen_reg, seen_next;
    logic [31:0]               row_reg, row_next;
    logic [31:0]               line_reg, line_next;
    logic                      cr_reg, cr_next;

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] v);
        return (v == csv_tok_pkg::POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == csv_tok_pkg::CH_SPACE) ||
               (c >= csv_tok_pkg::CH_TAB && c <= csv_tok_pkg::CH_CR);
    endfunction

    function automatic csv_tok_pkg::event_t field_event(
        input logic [PW-1:0] endp,
        input logic [PW-1:0] fb,
        input logic [PW-1:0] fn,
        input logic [PW-1:0] ne,
        input logic          seen,
        input logic          trim
    );
        csv_tok_pkg::event_t ev;
        logic [PW-1:0]       e;
        logic [PW-1:0]       stop;
        logic [PW-1:0]       off;
        logic [PW-1:0]       len;
        stop = (endp < fb) ? fb : endp;
        if (!trim)
        begin
            off = fb;
            len = stop - fb;
        end
        else if (seen)
        begin
            e   = (ne > stop) ? stop : ne;
            off = fn;
            len = (e > fn) ? e - fn : '0;
        end
        else
        begin
            off = stop;
            len = '0;
        end
        ev        = '0;
        ev.kind   = csv_tok_pkg::EV_FIELD;
        ev.offset = 32'(off);
        ev.length = 32'(len);
        return ev;
    endfunction

    function automatic csv_tok_pkg::event_t mark_event(
        input csv_tok_pkg::event_kind_t kind,
        input logic [PW-1:0]            off
    );
        csv_tok_pkg::event_t ev;
        ev        = '0;
        ev.kind   = kind;
        ev.offset = 32'(off);
        return ev;
    endfunction

    assign fire     = ib_valid_reg && room;
    assign in_stall = ib_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        ib_valid_next = ib_valid_reg;
        if (accept)
            ib_valid_next = 1'b1;
        else if (fire)
            ib_valid_next = 1'b0;
    end

    always_comb
    begin
        csv_tok_pkg::quote_state_t st;
        csv_tok_pkg::event_t       slot [2];
        logic [1:0]                n;
        logic [1:0]                n_out;
        logic [7:0]                c;
        logic [PW-1:0]             p;
        logic [PW-1:0]             nx;
        logic [PW-1:0]             endp;
        logic                      skip;
        logic                      trim;
        logic                      rfc;
        logic                      inwin;
        logic                      empty;
        logic                      crb;

        c    = ib_byte_reg;
        p    = pos_reg;
        nx   = pos_inc(pos_reg);
        skip = cfg.option_bits[0];
        trim = cfg.option_bits[1];
        rfc  = (cfg.escape_byte == 8'd0) || (cfg.escape_byte == cfg.quote_byte);
        inwin = (line_reg >= cfg.first_line) &&
                (cfg.last_line == 32'd0 || line_reg <= cfg.last_line);

        slot[0] = '0;
        slot[1] = '0;
        n       = 2'd0;
        st      = qs_reg;
        empty   = 1'b0;
        crb     = 1'b0;
        endp    = '0;

        qs_next      = qs_reg;
        comment_next = comment_reg;
        disc_next    = disc_reg;
        pos_next     = pos_reg;
        fb_next      = fb_reg;
        fn_next      = fn_reg;
        ne_next      = ne_reg;
        seen_next    = seen_reg;
        row_next     = row_reg;
        line_next    = line_reg;
        cr_next      = cr_reg;

        if (!disc_reg && comment_reg)
        begin
            if (c == csv_tok_pkg::CH_LF)
            begin
                comment_next = 1'b0;
                if (row_reg != 32'd0)
                begin
                    slot[n[0]] = mark_event(csv_tok_pkg::EV_ROW_END, '0);
                    n = n + 2'd1;
                end
                if (line_reg != csv_tok_pkg::COUNT_MAX)
                    line_next = line_reg + 32'd1;
                row_next  = 32'd0;
                cr_next   = 1'b0;
                fb_next   = nx;
                fn_next   = nx;
                ne_next   = nx;
                seen_next = 1'b0;
            end
        end
        else if (!disc_reg)
        begin
            if (st == csv_tok_pkg::Q_ESCAPE && rfc && c != cfg.quote_byte)
                st = csv_tok_pkg::Q_UNQUOTED;
            if (st == csv_tok_pkg::Q_UNQUOTED && c == csv_tok_pkg::CH_LF)
            begin
                empty = (row_reg == (cr_reg ? 32'd1 : 32'd0));
                if (!(skip && empty))
                begin
                    // a cr right before the lf is not part of the field
                    endp = cr_reg ? ((p != '0) ? p - 1'b1 : '0) : p;
                    slot[n[0]] = field_event(endp, fb_reg, fn_reg, ne_reg, seen_reg, trim);
                    n = n + 2'd1;
                    slot[n[0]] = mark_event(csv_tok_pkg::EV_ROW_END, '0);
                    n = n + 2'd1;
                end
                qs_next = csv_tok_pkg::Q_UNQUOTED;
                if (line_reg != csv_tok_pkg::COUNT_MAX)
                    line_next = line_reg + 32'd1;
                row_next  = 32'd0;
                cr_next   = 1'b0;
                fb_next   = nx;
                fn_next   = nx;
                ne_next   = nx;
                seen_next = 1'b0;
            end
            else if (st == csv_tok_pkg::Q_UNQUOTED && cfg.comment_byte != 8'd0 &&
                     c == cfg.comment_byte)
            begin
                if (row_reg != 32'd0)
                begin
                    slot[n[0]] = field_event(p, fb_reg, fn_reg, ne_reg, seen_reg, trim);
                    n = n + 2'd1;
                end
                comment_next = 1'b1;
                cr_next      = 1'b0;
                qs_next      = csv_tok_pkg::Q_UNQUOTED;
            end
            else if (cfg.max_row_bytes != 32'd0 && row_reg >= cfg.max_row_bytes)
            begin
                slot[n[0]] = mark_event(csv_tok_pkg::EV_ROW_TOO_LONG, p);
                n = n + 2'd1;
                disc_next = 1'b1;
                qs_next   = csv_tok_pkg::Q_UNQUOTED;
                cr_next   = 1'b0;
            end
            else
            begin
                if (row_reg != csv_tok_pkg::COUNT_MAX)
                    row_next = row_reg + 32'd1;
                if (st == csv_tok_pkg::Q_UNQUOTED && c == cfg.delimiter_byte)
                begin
                    slot[n[0]] = field_event(p, fb_reg, fn_reg, ne_reg, seen_reg, trim);
                    n = n + 2'd1;
                    fb_next   = nx;
                    fn_next   = nx;
                    ne_next   = nx;
                    seen_next = 1'b0;
                end
                else
                begin
                    if (st == csv_tok_pkg::Q_UNQUOTED)
                    begin
                        if (c == cfg.quote_byte)
                            st = csv_tok_pkg::Q_QUOTED;
                        else if (c == csv_tok_pkg::CH_CR)
                            crb = 1'b1;
                    end
                    else if (st == csv_tok_pkg::Q_QUOTED)
                    begin
                        if (!rfc && c == cfg.escape_byte)
                            st = csv_tok_pkg::Q_ESCAPE;
                        else if (c == cfg.quote_byte)
                            st = rfc ? csv_tok_pkg::Q_ESCAPE : csv_tok_pkg::Q_UNQUOTED;
                    end
                    else
                    begin
                        st = csv_tok_pkg::Q_QUOTED;
                    end
                    if (!is_space(c))
                    begin
                        if (!seen_reg)
                        begin
                            fn_next   = p;
                            seen_next = 1'b1;
                        end
                        ne_next = nx;
                    end
                end
                qs_next = st;
                cr_next = crb;
            end
        end

        // discarded row ends at the next lf whatever its quoting
        if (disc_next && c == csv_tok_pkg::CH_LF)
        begin
            disc_next = 1'b0;
            if (line_reg != csv_tok_pkg::COUNT_MAX)
                line_next = line_reg + 32'd1;
            row_next  = 32'd0;
            cr_next   = 1'b0;
            fb_next   = nx;
            fn_next   = nx;
            ne_next   = nx;
            seen_next = 1'b0;
        end

        if (ib_eoi_reg)
        begin
            if (!disc_next && row_next != 32'd0)
            begin
                if (comment_next)
                begin
                    slot[n[0]] = mark_event(csv_tok_pkg::EV_ROW_END, '0);
                    n = n + 2'd1;
                end
                else
                begin
                    endp  = cr_next ? p : nx;
                    empty = (row_next == (cr_next ? 32'd1 : 32'd0));
                    if (!(skip && empty))
                    begin
                        if (endp > fb_next)
                        begin
                            slot[n[0]] = field_event(endp, fb_next, fn_next, ne_next,
                                                     seen_next, trim);
                            n = n + 2'd1;
                        end
                        slot[n[0]] = mark_event(csv_tok_pkg::EV_ROW_END, '0);
                        n = n + 2'd1;
                    end
                end
                if (line_next != csv_tok_pkg::COUNT_MAX)
                    line_next = line_next + 32'd1;
            end
            qs_next      = csv_tok_pkg::Q_UNQUOTED;
            comment_next = 1'b0;
            disc_next    = 1'b0;
            cr_next      = 1'b0;
            row_next     = 32'd0;
            pos_next     = '0;
            fb_next      = '0;
            fn_next      = '0;
            ne_next      = '0;
            seen_next    = 1'b0;
        end
        else
        begin
            pos_next = nx;
        end

        // line number seen by every event of this beat is the one before the update
        slot[0].line = line_reg;
        slot[1].line = line_reg;
        n_out = (inwin && fire) ? n : 2'd0;
        if (n_out == 2'd1)
            slot[0].last = 1'b1;
        if (n_out == 2'd2)
            slot[1].last = 1'b1;
        push.count = n_out;
        push.ev[0] = slot[0];
        push.ev[1] = slot[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_valid_reg <= 1'b0;
            qs_reg       <= csv_tok_pkg::Q_UNQUOTED;
            comment_reg  <= 1'b0;
            disc_reg     <= 1'b0;
            pos_reg      <= '0;
            fb_reg       <= '0;
            fn_reg       <= '0;
            ne_reg       <= '0;
            seen_reg     <= 1'b0;
            row_reg      <= 32'd0;
            line_reg     <= 32'd1;
            cr_reg       <= 1'b0;
        end
        else
        begin
            ib_valid_reg <= ib_valid_next;
            if (fire)
            begin
                qs_reg      <= qs_next;
                comment_reg <= comment_next;
                disc_reg    <= disc_next;
                pos_reg     <= pos_next;
                fb_reg      <= fb_next;
                fn_reg      <= fn_next;
                ne_reg      <= ne_next;
                seen_reg    <= seen_next;
                row_reg     <= row_next;
                line_reg    <= line_next;
                cr_reg      <= cr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ib_byte_reg <= data_byte;
            ib_eoi_reg  <= end_of_input;
        end
    end

endmodule

FILE: hw/rtl/csv_tok_fifo.sv
// small result queue taking up to two events a cycle and giving one while not stalled
module csv_tok_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csv_tok_pkg::push_t   push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output csv_tok_pkg::event_t  head
);

    localparam int AW = csv_tok_pkg::FIFO_AW;

    csv_tok_pkg::event_t mem [csv_tok_pkg::FIFO_DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [AW:0]         count_reg, count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = mem[rd_ptr_reg];
    // two free entries so a beat that yields two events always fits
    assign room      = (count_reg <= (AW+1)'(csv_tok_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(push.count) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.ev[0];
        if (push.count == 2'd2)
            mem[wr_ptr_reg + AW'(1)] <= push.ev[1];
    end

endmodule

FILE: hw/rtl/csv_tok_checker.sv
// port-level checks of the csv byte tokenizer, bound to the top level
module csv_tok_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  event_kind,
    input logic [31:0] field_offset,
    input logic [31:0] field_length,
    input logic [31:0] line_number,
    input logic        last_of_run
);

    // a held result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(event_kind) && $stable(field_offset) &&
            $stable(field_length) && $stable(line_number) && $stable(last_of_run))
        else $error("result beat changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_kind == csv_tok_pkg::EV_FIELD ||
            event_kind == csv_tok_pkg::EV_ROW_END ||
            event_kind == csv_tok_pkg::EV_ROW_TOO_LONG)
        else $error("undefined event kind");

    a_row_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == csv_tok_pkg::EV_ROW_END |->
            field_offset == 32'd0 && field_length == 32'd0 && last_of_run)
        else $error("row end with offset, length or not last");

    a_error_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == csv_tok_pkg::EV_ROW_TOO_LONG |->
            field_length == 32'd0 && line_number != 32'd0)
        else $error("row too long event with length or no line");

endmodule

bind csv_byte_tokenizer csv_tok_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .field_offset (field_offset),
    .field_length (field_length),
    .line_number  (line_number),
    .last_of_run  (last_of_run)
);
